// ===== rtl/ntct_pkg.sv =====
// Package for the NAT TCP connection tracker: phase codes, flag bits, entry record.
// No dependencies.
package ntct_pkg;

  localparam logic [2:0] PH_WAIT_SYNACK = 3'd1;
  localparam logic [2:0] PH_WAIT_ACK    = 3'd2;
  localparam logic [2:0] PH_EST         = 3'd3;
  localparam logic [2:0] PH_FIN         = 3'd4;
  localparam logic [2:0] PH_NONE        = 3'd5;

  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_ACK = 2;

  localparam logic CFG_TRANS = 1'b0;
  localparam logic CFG_EST   = 1'b1;

  // One table entry as stored in the entry RAM (mapping kept 12 bits wide).
  typedef struct packed {
    logic [11:0] mapping;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [2:0]  phase;
    logic [31:0] active_seq;
    logic [31:0] passive_seq;
    logic [31:0] last_seen;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

// ===== rtl/nat_tcp_connection_tracker.sv =====
// NAT TCP connection tracker top level: entry RAM scan, update and expiry.
// Depends on ntct_pkg and ntct_ram.
// Flow: a packet or tick is accepted, every entry is scanned (the single-port entry
// RAM is read one entry per cycle), the matched entry is re-read, then updated.
// One item is in work at a time; the next can be taken in the cycle in which the
// result is raised. A result not yet taken holds the following item before its
// write-back.
// Reset: valid bits, seconds counter and control clear at once; timeouts reset to
// 300 and 7440. The RAM contents are not cleared, valid bits gate them.
module nat_tcp_connection_tracker
  import ntct_pkg::*;
#(
  parameter int CONN_ENTRIES    = 64,
  parameter int MAPPING_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        mapping_found_i,
  input  logic [5:0]  mapping_id_i,
  input  logic        from_inside_i,
  input  logic [31:0] src_ip_i,
  input  logic [15:0] src_port_i,
  input  logic [31:0] dst_ip_i,
  input  logic [15:0] dst_port_i,
  input  logic [2:0]  tcp_flags_i,
  input  logic [31:0] seq_no_i,
  input  logic [31:0] ack_no_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        conn_found_o,
  output logic        conn_created_o,
  output logic        table_full_o,
  output logic [2:0]  conn_state_o,
  output logic [6:0]  removed_count_o
);
  localparam int AW = $clog2(CONN_ENTRIES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,  // reading entries, one per cycle
    ST_RDHIT = 4'b0100,  // re-read the matched entry, wait for the result register
    ST_UPD   = 4'b1000   // write back and form the result
  } state_e;

  state_e state_q, state_d;

  logic [15:0] trans_to_q, est_to_q;
  logic [31:0] now_q;
  logic [CONN_ENTRIES-1:0] valid_q;

  // item held during processing
  logic        tick_q;
  logic        map_ok_q;
  logic [11:0] map_q;
  logic [31:0] rip_q, seq_q, ack_q;
  logic [15:0] rport_q;
  logic [2:0]  flags_q;

  logic [AW:0]   cnt_q;      // issued read address, AW+1 wide to reach the depth
  logic          rd_v_q;     // read data valid this cycle
  logic [AW-1:0] rd_a_q;     // its address
  logic          hit_q;
  logic [AW-1:0] hit_a_q;
  logic          free_q;
  logic [AW-1:0] free_a_q;
  logic [6:0]    rem_q;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  entry_t        ram_wd, ram_rd;

  ntct_ram #(.Width(EntryW), .Depth(CONN_ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wd),
    .rdata_o(ram_rd)
  );

  // results
  logic       o_found_q, o_created_q, o_full_q;
  logic [2:0] o_state_q;
  logic [6:0] o_rem_q;
  logic       out_v_q;

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_v_q;
  assign conn_found_o    = o_found_q;
  assign conn_created_o  = o_created_q;
  assign table_full_o    = o_full_q;
  assign conn_state_o    = o_state_q;
  assign removed_count_o = o_rem_q;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  logic scan_last;
  assign scan_last = (cnt_q == (AW+1)'(CONN_ENTRIES));

  // compare on scanned entry
  logic        match;
  logic [31:0] age;
  logic [31:0] lim;
  logic        expire;
  assign match  = rd_v_q && valid_q[rd_a_q] && ram_rd.mapping == map_q &&
                  ram_rd.remote_ip == rip_q && ram_rd.remote_port == rport_q;
  assign age    = now_q - ram_rd.last_seen;
  assign lim    = {16'd0, (ram_rd.phase == PH_EST) ? est_to_q : trans_to_q};
  assign expire = rd_v_q && valid_q[rd_a_q] && (age >= lim);

  logic syn, ackf, fin, syn_only;
  assign fin      = flags_q[FLAG_FIN];
  assign syn      = flags_q[FLAG_SYN];
  assign ackf     = flags_q[FLAG_ACK];
  assign syn_only = syn && !ackf;

  // update logic for ST_UPD
  entry_t     upd;
  logic [2:0] ph;
  always_comb begin
    upd = ram_rd;
    ph  = ram_rd.phase;
    if (syn && ackf && ack_q == ram_rd.active_seq + 32'd1 && ram_rd.phase == PH_WAIT_SYNACK) begin
      upd.passive_seq = seq_q;
      ph = PH_WAIT_ACK;
    end else if (ackf && ack_q == ram_rd.passive_seq + 32'd1 && ram_rd.phase == PH_WAIT_ACK) begin
      ph = PH_EST;
    end
    if (fin) ph = PH_FIN;
    upd.phase     = ph;
    upd.last_seen = now_q;
  end

  entry_t newe;
  always_comb begin
    newe.mapping     = map_q;
    newe.remote_ip   = rip_q;
    newe.remote_port = rport_q;
    newe.phase       = PH_WAIT_SYNACK;
    newe.active_seq  = seq_q;
    newe.passive_seq = 32'd0;
    newe.last_seen   = now_q;
  end

  logic create;
  assign create = (state_q == ST_UPD) && map_ok_q && !tick_q && syn_only && !hit_q && free_q;

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = cnt_q[AW-1:0];
    ram_wd   = newe;
    if (state_q == ST_RDHIT) ram_addr = hit_a_q;
    if (state_q == ST_UPD) begin
      if (create) begin
        ram_we   = 1'b1;
        ram_addr = free_a_q;
      end else if (hit_q && !syn_only && map_ok_q && !tick_q) begin
        ram_we   = 1'b1;
        ram_addr = hit_a_q;
        ram_wd   = upd;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      ST_SCAN:  if (scan_last && !rd_v_q) state_d = ST_RDHIT;
      ST_RDHIT: if (!out_v_q) state_d = ST_UPD;
      ST_UPD:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      trans_to_q <= 16'd300;
      est_to_q <= 16'd7440;
      now_q    <= '0;
      valid_q  <= '0;
      out_v_q  <= 1'b0;
      cnt_q    <= '0;
      rd_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TRANS) trans_to_q <= cfg_wdata_i;
        else est_to_q <= cfg_wdata_i;
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (accept) begin
        cnt_q  <= '0;
        rd_v_q <= 1'b0;
        if (kind_i) now_q <= now_q + 32'd1;
      end
      if (state_q == ST_SCAN) begin
        rd_v_q <= !scan_last;
        if (!scan_last) cnt_q <= cnt_q + (AW+1)'(1);
        if (tick_q && expire) valid_q[rd_a_q] <= 1'b0;
      end
      if (create) valid_q[free_a_q] <= 1'b1;
      if (state_q == ST_UPD) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tick_q   <= kind_i;
      map_ok_q <= mapping_found_i && (32'(mapping_id_i) < 32'(MAPPING_ENTRIES));
      map_q    <= {6'd0, mapping_id_i};
      rip_q    <= from_inside_i ? dst_ip_i : src_ip_i;
      rport_q  <= from_inside_i ? dst_port_i : src_port_i;
      flags_q  <= tcp_flags_i;
      seq_q    <= seq_no_i;
      ack_q    <= ack_no_i;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      rem_q    <= '0;
    end
    if (state_q == ST_SCAN) begin
      rd_a_q <= cnt_q[AW-1:0];
      if (match && !hit_q) begin
        hit_q   <= 1'b1;
        hit_a_q <= rd_a_q;
      end
      if (rd_v_q && !valid_q[rd_a_q] && !free_q) begin
        free_q   <= 1'b1;
        free_a_q <= rd_a_q;
      end
      if (tick_q && expire && rem_q != 7'd127) rem_q <= rem_q + 7'd1;
    end
    if (state_q == ST_UPD) begin
      o_found_q   <= 1'b0;
      o_created_q <= 1'b0;
      o_full_q    <= 1'b0;
      o_state_q   <= PH_NONE;
      o_rem_q     <= tick_q ? rem_q : 7'd0;
      if (!tick_q && map_ok_q) begin
        if (hit_q) begin
          o_found_q <= 1'b1;
          o_state_q <= syn_only ? ram_rd.phase : ph;
        end else if (syn_only) begin
          if (free_q) begin
            o_created_q <= 1'b1;
            o_state_q   <= PH_WAIT_SYNACK;
          end else begin
            o_full_q <= 1'b1;
          end
        end
      end
    end
  end

  // result only raised from the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q) == ST_UPD)
    else $error("result raised outside update");
  // no item taken while one is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("ready while busy");
  // creation and full are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(o_created_q && o_full_q))
    else $error("created and full together");
endmodule

// ===== rtl/ntct_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module ntct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== verif/tb_nat_tcp_connection_tracker.sv =====
// Testbench for the NAT TCP connection tracker: directed and random packet/tick items,
// checked against a behavioral table model kept in the testbench. Depends on ntct_pkg.
module tb_nat_tcp_connection_tracker;
  import ntct_pkg::*;

  localparam int NUM_CONN  = 64;
  localparam int NUM_MAP   = 64;
  localparam int MAX_CYC   = 2000000;
  localparam int DRAIN_CYC = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_TRANS;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic        mapping_found_i = 1'b0;
  logic [5:0]  mapping_id_i = '0;
  logic        from_inside_i = 1'b0;
  logic [31:0] src_ip_i = '0;
  logic [15:0] src_port_i = '0;
  logic [31:0] dst_ip_i = '0;
  logic [15:0] dst_port_i = '0;
  logic [2:0]  tcp_flags_i = '0;
  logic [31:0] seq_no_i = '0;
  logic [31:0] ack_no_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        conn_found_o;
  logic        conn_created_o;
  logic        table_full_o;
  logic [2:0]  conn_state_o;
  logic [6:0]  removed_count_o;

  nat_tcp_connection_tracker u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // One item as sent to the block.
  typedef struct {
    logic        tick;
    logic        found;
    logic [5:0]  map;
    logic        outbound;
    logic [31:0] sip;
    logic [15:0] sport;
    logic [31:0] dip;
    logic [15:0] dport;
    logic [2:0]  flags;
    logic [31:0] seq;
    logic [31:0] ack;
  } pkt_t;

  typedef struct {
    logic       found;
    logic       created;
    logic       full;
    logic [2:0] state;
    logic [6:0] removed;
  } verdict_t;

  // Shadow connection table.
  logic        tbl_valid [NUM_CONN];
  logic [5:0]  tbl_map   [NUM_CONN];
  logic [31:0] tbl_ip    [NUM_CONN];
  logic [15:0] tbl_port  [NUM_CONN];
  logic [2:0]  tbl_phase [NUM_CONN];
  logic [31:0] tbl_aseq  [NUM_CONN];
  logic [31:0] tbl_pseq  [NUM_CONN];
  logic [31:0] tbl_seen  [NUM_CONN];
  logic [31:0] clock_secs;
  logic [15:0] trans_to;
  logic [15:0] est_to;

  verdict_t expected_verdicts[$];
  int       errors;
  int       cycles;
  int       hold_off;   // long receiver stall, counted down by the sink

  // Remote endpoints in use; random traffic mostly reuses them so handshakes
  // actually progress.
  typedef struct {
    logic [5:0]  map;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] aseq;
    logic [31:0] pseq;
  } peer_t;
  peer_t peers[$];

  function automatic verdict_t track_connection(pkt_t p);
    verdict_t    v;
    int          hit;
    int          slot;
    int          cnt;
    logic [31:0] rip;
    logic [15:0] rport;
    logic        fin, syn, ackf;
    v = '{1'b0, 1'b0, 1'b0, PH_NONE, 7'd0};
    if (p.tick) begin
      cnt = 0;
      clock_secs = clock_secs + 32'd1;
      for (int i = 0; i < NUM_CONN; i++) begin
        if (tbl_valid[i] && (clock_secs - tbl_seen[i]) >=
            ((tbl_phase[i] == PH_EST) ? {16'd0, est_to} : {16'd0, trans_to})) begin
          tbl_valid[i] = 1'b0;
          cnt++;
        end
      end
      v.removed = (cnt > 127) ? 7'd127 : cnt[6:0];
      return v;
    end
    if (!p.found || int'(p.map) >= NUM_MAP) return v;
    rip   = p.outbound ? p.dip : p.sip;
    rport = p.outbound ? p.dport : p.sport;
    fin   = p.flags[FLAG_FIN];
    syn   = p.flags[FLAG_SYN];
    ackf  = p.flags[FLAG_ACK];
    hit = -1;
    slot = -1;
    for (int i = NUM_CONN - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_map[i] == p.map && tbl_ip[i] == rip && tbl_port[i] == rport)
        hit = i;
      if (!tbl_valid[i]) slot = i;
    end
    if (syn && !ackf) begin
      if (hit >= 0) begin
        v.found = 1'b1;
        v.state = tbl_phase[hit];
      end else if (slot < 0) begin
        v.full = 1'b1;
      end else begin
        tbl_valid[slot] = 1'b1;
        tbl_map[slot]   = p.map;
        tbl_ip[slot]    = rip;
        tbl_port[slot]  = rport;
        tbl_phase[slot] = PH_WAIT_SYNACK;
        tbl_aseq[slot]  = p.seq;
        tbl_pseq[slot]  = '0;
        tbl_seen[slot]  = clock_secs;
        v.created = 1'b1;
        v.state = PH_WAIT_SYNACK;
      end
    end else if (hit >= 0) begin
      v.found = 1'b1;
      if (syn && ackf && p.ack == tbl_aseq[hit] + 32'd1 && tbl_phase[hit] == PH_WAIT_SYNACK)
      begin
        tbl_pseq[hit]  = p.seq;
        tbl_phase[hit] = PH_WAIT_ACK;
      end else if (ackf && p.ack == tbl_pseq[hit] + 32'd1 && tbl_phase[hit] == PH_WAIT_ACK)
      begin
        tbl_phase[hit] = PH_EST;
      end
      if (fin) tbl_phase[hit] = PH_FIN;
      tbl_seen[hit] = clock_secs;
      v.state = tbl_phase[hit];
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Random gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  // Valid stays up after an accept until the next call drops it or replaces the item.
  task automatic send_item(pkt_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= p.tick;
    mapping_found_i <= p.found;
    mapping_id_i    <= p.map;
    from_inside_i   <= p.outbound;
    src_ip_i        <= p.sip;
    src_port_i      <= p.sport;
    dst_ip_i        <= p.dip;
    dst_port_i      <= p.dport;
    tcp_flags_i     <= p.flags;
    seq_no_i        <= p.seq;
    ack_no_i        <= p.ack;
    do @(posedge clk_i); while (!in_ready_o);
    expected_verdicts.push_back(track_connection(p));
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);  // let any in-flight scan finish
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TRANS) trans_to = val;
    else est_to = val;
  endtask

  function automatic pkt_t make_tick();
    pkt_t p;
    p = '{1'b1, 1'($urandom), 6'($urandom), 1'($urandom), $urandom, 16'($urandom),
          $urandom, 16'($urandom), 3'($urandom), $urandom, $urandom};
    return p;
  endfunction

  // Packet aimed at a peer, direction chosen at random.
  function automatic pkt_t peer_pkt(peer_t pr, logic [2:0] flags, logic [31:0] seq,
                                    logic [31:0] ack);
    pkt_t p;
    p = '{1'b0, 1'b1, pr.map, 1'($urandom), $urandom, 16'($urandom), $urandom,
          16'($urandom), flags, seq, ack};
    if (p.outbound) begin
      p.dip = pr.ip;
      p.dport = pr.port;
    end else begin
      p.sip = pr.ip;
      p.sport = pr.port;
    end
    return p;
  endfunction

  function automatic peer_t rand_peer();
    peer_t pr;
    pr.map  = 6'($urandom);
    pr.ip   = $urandom;
    pr.port = 16'($urandom);
    pr.aseq = $urandom;
    pr.pseq = $urandom;
    return pr;
  endfunction

  // Full three-way handshake and a FIN, plus SYN repeat and missing-mapping cases.
  task automatic test_directed();
    peer_t pr;
    pkt_t  p;
    pr = '{6'd63, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    send_item(peer_pkt(pr, 3'b010, pr.aseq, 32'd0));
    send_item(peer_pkt(pr, 3'b010, 32'd5, 32'd0));                 // SYN on existing entry
    send_item(peer_pkt(pr, 3'b110, pr.pseq, pr.aseq + 32'd2));     // wrong ack, no move
    send_item(peer_pkt(pr, 3'b110, pr.pseq, pr.aseq + 32'd1));     // SYN-ACK, wraps to 0
    send_item(peer_pkt(pr, 3'b100, 32'd0, pr.pseq + 32'd1));       // ACK -> established
    send_item(peer_pkt(pr, 3'b101, 32'd0, 32'd0));                 // FIN
    pr = '{6'd0, 32'd0, 16'd0, 32'd0, 32'hFFFF_FFFF};
    send_item(peer_pkt(pr, 3'b011, 32'd0, 32'd0));                 // SYN+FIN creates
    send_item(peer_pkt(pr, 3'b111, pr.pseq, 32'd1));
    send_item(peer_pkt(pr, 3'b100, 32'd0, 32'd0));                 // ack wraps
    p = peer_pkt(rand_peer(), 3'b010, 32'd1, 32'd1);
    p.found = 1'b0;                                                // no mapping
    send_item(p);
    send_item(peer_pkt(rand_peer(), 3'b001, 32'd1, 32'd1));        // unmatched non-SYN
    send_item(peer_pkt(rand_peer(), 3'b000, 32'd1, 32'd1));
    send_item(make_tick());
  endtask

  // Fill all entries, overflow, then expire them with short timeouts.
  task automatic test_table_full();
    write_reg(CFG_TRANS, 16'd1);
    write_reg(CFG_EST, 16'd1);
    send_item(make_tick());                   // clear leftovers
    for (int i = 0; i < NUM_CONN + 2; i++)
      send_item(peer_pkt(rand_peer(), 3'b010, $urandom, 32'd0));
    send_item(make_tick());                   // removes all 64
    write_reg(CFG_TRANS, 16'd0);              // zero timeout
    write_reg(CFG_EST, 16'hFFFF);
    send_item(peer_pkt(rand_peer(), 3'b010, 32'd7, 32'd0));
    send_item(make_tick());
  endtask

  // Random traffic with handshakes on a pool of peers, timeouts varied by phase.
  task automatic test_random(int n, logic [15:0] tt, logic [15:0] et);
    peer_t pr;
    pkt_t  p;
    int    k, r;
    write_reg(CFG_TRANS, tt);
    write_reg(CFG_EST, et);
    for (int i = 0; i < n; i++) begin
      if (peers.size() < 8 || $urandom_range(0, 9) == 0) begin
        pr = rand_peer();
        if ($urandom_range(0, 3) == 0) pr.map = 6'($urandom_range(0, 3));
        peers.push_back(pr);
        if (peers.size() > 40) peers.delete(0);
      end
      k = $urandom_range(0, peers.size() - 1);
      pr = peers[k];
      r = $urandom_range(0, 99);
      if (r < 12) p = make_tick();
      else if (r < 30) p = peer_pkt(pr, 3'b010, pr.aseq, $urandom);
      else if (r < 48) p = peer_pkt(pr, 3'b110, pr.pseq, pr.aseq + 32'd1);
      else if (r < 66) p = peer_pkt(pr, 3'b100, $urandom, pr.pseq + 32'd1);
      else if (r < 72) p = peer_pkt(pr, 3'b001 | 3'($urandom_range(0, 7)), $urandom, $urandom);
      else if (r < 85) p = peer_pkt(pr, 3'($urandom), $urandom, $urandom);
      else begin
        p = peer_pkt(rand_peer(), 3'($urandom), $urandom, $urandom);
        p.found = 1'($urandom);
      end
      send_item(p);
    end
  endtask

  // Receiver stalls for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_item(peer_pkt(rand_peer(), 3'b010, $urandom, 32'd0));
  endtask

  // Result sink with random stalls.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("unexpected result at cycle %0d", cycles);
        errors++;
      end else begin
        verdict_t w;
        w = expected_verdicts[0];
        expected_verdicts.delete(0);
        if (conn_found_o !== w.found) report_mismatch("conn_found", conn_found_o, w.found);
        if (conn_created_o !== w.created)
          report_mismatch("conn_created", conn_created_o, w.created);
        if (table_full_o !== w.full) report_mismatch("table_full", table_full_o, w.full);
        if (conn_state_o !== w.state) report_mismatch("conn_state", conn_state_o, w.state);
        if (removed_count_o !== w.removed)
          report_mismatch("removed_count", removed_count_o, w.removed);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (cycles > MAX_CYC) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    hold_off = 0;
    clock_secs = '0;
    trans_to = 16'd300;
    est_to = 16'd7440;
    for (int i = 0; i < NUM_CONN; i++) tbl_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(400, 16'd3, 16'd9);
    test_random(350, 16'd1, 16'd65535);
    test_random(300, 16'd65535, 16'd2);
    write_reg(CFG_TRANS, 16'd300);
    write_reg(CFG_EST, 16'd7440);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
